[src/mwpe_pkg.sv]
// Shared types and constants for the mean wrapped position error block.
package mwpe_pkg;

  localparam int unsigned COORD_W       = 16;
  localparam int unsigned MAX_PARTICLES = 1024;
  localparam int unsigned CNT_W         = 11;
  localparam int unsigned SUM_W         = 26;
  localparam int unsigned WRAP_STEPS    = COORD_W + 1;
  localparam int unsigned ROOT_STEPS    = 16;
  localparam int unsigned DIV_STEPS     = SUM_W;
  localparam int unsigned STEP_W        = $clog2(DIV_STEPS);
  localparam int unsigned REG_IDX_W     = 2;

  localparam logic [REG_IDX_W-1:0] REG_WORLD_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WORLD_HEIGHT = 2'd1;

  localparam logic [COORD_W-1:0] WORLD_RESET = 16'd25600;
  localparam logic [COORD_W-1:0] MAX_ERROR   = 16'd46341;

  typedef struct packed {
    logic load;
    logic wrap_step;
    logic wrap_fix;
    logic square;
    logic root_init;
    logic root_step;
    logic accum;
    logic div_init;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic full;
    logic out_busy;
  } dp_stat_t;

endpackage

[src/mwpe_wrap_lane.sv]
// One axis: wraps a coordinate difference onto the cyclic extent and takes its magnitude.
module mwpe_wrap_lane (
  input  logic                    clk_i,
  input  logic [15:0]             a_i,
  input  logic [15:0]             b_i,
  input  logic [15:0]             extent_i,
  input  mwpe_pkg::dp_cmd_t       cmd_i,
  output logic [15:0]             abs_o
);
  import mwpe_pkg::*;

  logic [15:0] w_eff, h_eff;
  logic [17:0] diff;
  logic [17:0] diff_neg;
  logic [16:0] trial, trial_sub;
  logic [15:0] m_val;
  logic [16:0] v_val, v_neg;

  logic [15:0] w_q, h_q, rem_q, rem_d, abs_q, abs_d;
  logic [16:0] num_q;
  logic        neg_q;

  always_comb begin
    w_eff     = (extent_i == 16'd0) ? 16'd1 : extent_i;
    h_eff     = w_eff >> 1;
    diff      = {2'b00, a_i} - {2'b00, b_i} + {2'b00, h_eff};
    diff_neg  = 18'd0 - diff;
    trial     = {rem_q, num_q[16]};
    trial_sub = trial - {1'b0, w_q};
    if (trial >= {1'b0, w_q}) begin
      rem_d = trial_sub[15:0];
    end else begin
      rem_d = trial[15:0];
    end
    m_val = (neg_q && rem_q != 16'd0) ? (w_q - rem_q) : rem_q;
    v_val = {1'b0, m_val} - {1'b0, h_q};
    v_neg = 17'd0 - v_val;
    abs_d = v_val[16] ? v_neg[15:0] : v_val[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q   <= w_eff;
      h_q   <= h_eff;
      neg_q <= diff[17];
      num_q <= diff[17] ? diff_neg[16:0] : diff[16:0];
      rem_q <= '0;
    end else if (cmd_i.wrap_step) begin
      rem_q <= rem_d;
      num_q <= {num_q[15:0], 1'b0};
    end
    if (cmd_i.wrap_fix) begin
      abs_q <= abs_d;
    end
  end

  assign abs_o = abs_q;

endmodule

[src/mwpe_datapath.sv]
// Datapath: configuration, axis lanes, squares, bit-serial root, sum and serial divider.
module mwpe_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [mwpe_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  input  logic [15:0]                      particle_x_i,
  input  logic [15:0]                      particle_y_i,
  input  logic [15:0]                      robot_x_i,
  input  logic [15:0]                      robot_y_i,
  input  logic                             last_particle_i,
  input  logic                             out_stall_i,
  input  mwpe_pkg::dp_cmd_t                cmd_i,
  output mwpe_pkg::dp_stat_t               stat_o,
  output logic                             out_valid_o,
  output logic [15:0]                      mean_error_o,
  output logic [mwpe_pkg::CNT_W-1:0]       particle_total_o
);
  import mwpe_pkg::*;

  logic [15:0]       width_q, height_q;
  logic              last_q;
  logic [15:0]       abs_x, abs_y;
  logic [31:0]       sq_x_q, sq_y_q;
  logic [31:0]       rad_q;
  logic [19:0]       rrem_q, rrem_d, rshift, rtrial;
  logic [15:0]       root_q, root_d;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  count_q, n_q;
  logic [SUM_W-1:0]  dq_q;
  logic [CNT_W-1:0]  drem_q, drem_d;
  logic [CNT_W:0]    dtrial, dtrial_sub;
  logic              dge;
  logic              out_valid_q;
  logic [15:0]       mean_q;
  logic [CNT_W-1:0]  total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WORLD_RESET;
      height_q <= WORLD_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_WORLD_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_WORLD_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  mwpe_wrap_lane u_lane_x (
    .clk_i    (clk_i),
    .a_i      (particle_x_i),
    .b_i      (robot_x_i),
    .extent_i (width_q),
    .cmd_i    (cmd_i),
    .abs_o    (abs_x)
  );

  mwpe_wrap_lane u_lane_y (
    .clk_i    (clk_i),
    .a_i      (particle_y_i),
    .b_i      (robot_y_i),
    .extent_i (height_q),
    .cmd_i    (cmd_i),
    .abs_o    (abs_y)
  );

  always_comb begin
    rshift = {rrem_q[17:0], rad_q[31:30]};
    rtrial = {2'b00, root_q, 2'b01};
    if (rshift >= rtrial) begin
      rrem_d = rshift - rtrial;
      root_d = {root_q[14:0], 1'b1};
    end else begin
      rrem_d = rshift;
      root_d = {root_q[14:0], 1'b0};
    end
    dtrial     = {drem_q, dq_q[SUM_W-1]};
    dtrial_sub = dtrial - {1'b0, n_q};
    dge        = (dtrial >= {1'b0, n_q});
    drem_d     = dge ? dtrial_sub[CNT_W-1:0] : dtrial[CNT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      last_q <= last_particle_i;
    end
    if (cmd_i.square) begin
      sq_x_q <= {16'd0, abs_x} * {16'd0, abs_x};
      sq_y_q <= {16'd0, abs_y} * {16'd0, abs_y};
    end
    if (cmd_i.root_init) begin
      rad_q  <= sq_x_q + sq_y_q;
      rrem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[29:0], 2'b00};
      rrem_q <= rrem_d;
      root_q <= root_d;
    end
    if (cmd_i.div_init) begin
      dq_q   <= sum_q;
      drem_q <= '0;
      n_q    <= (count_q == '0) ? CNT_W'(1) : count_q;
    end else if (cmd_i.div_step) begin
      dq_q   <= {dq_q[SUM_W-2:0], dge};
      drem_q <= drem_d;
    end
    if (cmd_i.emit) begin
      mean_q  <= dq_q[15:0];
      total_q <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        sum_q       <= '0;
        count_q     <= '0;
        out_valid_q <= 1'b1;
      end else begin
        if (cmd_i.accum) begin
          sum_q   <= sum_q + {{(SUM_W-16){1'b0}}, root_q};
          count_q <= count_q + CNT_W'(1);
        end
        if (out_valid_q && !out_stall_i) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  assign stat_o.last     = last_q;
  assign stat_o.full     = (count_q >= CNT_W'(MAX_PARTICLES));
  assign stat_o.out_busy = out_valid_q;

  assign out_valid_o      = out_valid_q;
  assign mean_error_o     = mean_q;
  assign particle_total_o = total_q;

endmodule

[src/mwpe_ctrl.sv]
// Controller: sequences wrap, square, root and accumulate for each item, and divide at the end of a set.
module mwpe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mwpe_pkg::dp_stat_t stat_i,
  output mwpe_pkg::dp_cmd_t  cmd_o
);
  import mwpe_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WRAP,
    ST_FIX,
    ST_SQUARE,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_ACCUM,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        step_d = '0;
        if (!stat_i.full) begin
          state_d = ST_WRAP;
        end else if (stat_i.last) begin
          state_d = ST_DIV_INIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WRAP: begin
        cmd_o.wrap_step = 1'b1;
        step_d          = step_q + STEP_W'(1);
        if (step_q == STEP_W'(WRAP_STEPS - 1)) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd_o.wrap_fix = 1'b1;
        state_d        = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_ROOT_INIT;
      end
      ST_ROOT_INIT: begin
        cmd_o.root_init = 1'b1;
        step_d          = '0;
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        step_d          = step_q + STEP_W'(1);
        if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = stat_i.last ? ST_DIV_INIT : ST_IDLE;
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

[src/mean_wrapped_position_error.sv]
// Top level of the mean wrapped position error block.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one particle and the robot position
//   per item; last_particle_i closes a set. Output channel (out_valid_o / out_stall_i)
//   carries the truncated mean distance and the particle count of the set.
//   Configuration writes (cfg_valid_i / cfg_ready_o, index 0 width, 1 height) are
//   always ready and are to be issued only while the block is idle.
// Sequence:
//   Each item passes through the two serial remainder lanes that wrap each axis, the
//   squares and the bit-serial square root, and is then accumulated; the input stalls
//   until it is through. A last item also runs the serial 26-bit divider before its
//   result is loaded into the output register.
//   Items beyond 1024 in a set are not accumulated.
// Reset:
//   Clears the sum, the count and the output valid; both extents return to 25600.
// Stall:
//   The result waits in the output register; the next set is processed meanwhile and
//   the block holds its own next result until the register is taken.
module mean_wrapped_position_error (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mwpe_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [15:0]                      particle_x_i,
  input  logic [15:0]                      particle_y_i,
  input  logic [15:0]                      robot_x_i,
  input  logic [15:0]                      robot_y_i,
  input  logic                             last_particle_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [15:0]                      mean_error_o,
  output logic [mwpe_pkg::CNT_W-1:0]       particle_total_o
);
  import mwpe_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  mwpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mwpe_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .particle_x_i     (particle_x_i),
    .particle_y_i     (particle_y_i),
    .robot_x_i        (robot_x_i),
    .robot_y_i        (robot_y_i),
    .last_particle_i  (last_particle_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .mean_error_o     (mean_error_o),
    .particle_total_o (particle_total_o)
  );

  a_accept_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while previous item still in work");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (particle_total_o != '0 &&
                     particle_total_o <= CNT_W'(MAX_PARTICLES)))
    else $error("particle total out of range");

  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (mean_error_o <= MAX_ERROR))
    else $error("mean error exceeds largest distance");

  a_emit_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !stat.out_busy)
    else $error("result loaded over a pending result");

endmodule

[tb/sv/mean_wrapped_position_error_test.sv]
// Self-checking testbench for the mean wrapped position error block.
module mean_wrapped_position_error_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mwpe_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS = 3;

  typedef struct packed {
    logic [15:0] particle_x;
    logic [15:0] particle_y;
    logic [15:0] robot_x;
    logic [15:0] robot_y;
    logic        last_particle;
  } particle_t;

  typedef struct packed {
    logic [15:0]      mean_error;
    logic [CNT_W-1:0] particle_total;
  } set_mean_t;

  class set_mean_checker;
    logic [15:0]     width_ext;
    logic [15:0]     height_ext;
    longint unsigned dist_sum;
    int unsigned     particles;
    set_mean_t       pending_means[$];
    int unsigned     errors;

    function new();
      width_ext  = WORLD_RESET;
      height_ext = WORLD_RESET;
      dist_sum   = 0;
      particles  = 0;
      errors     = 0;
    endfunction

    function void set_extent(logic [REG_IDX_W-1:0] idx, logic [15:0] val);
      if (idx == REG_WORLD_WIDTH) begin
        width_ext = val;
      end else if (idx == REG_WORLD_HEIGHT) begin
        height_ext = val;
      end
    endfunction

    function int unsigned pending();
      return pending_means.size();
    endfunction

    static function longint wrapped_delta(logic [15:0] a, logic [15:0] b, logic [15:0] ext);
      longint w, h, d, m;
      w = (ext == 0) ? 1 : longint'(ext);
      h = w / 2;
      d = longint'(a) - longint'(b) + h;
      m = d % w;
      if (m < 0) m += w;
      return m - h;
    endfunction

    static function longint unsigned floor_root(longint unsigned v);
      longint unsigned r, c;
      r = 0;
      for (int i = 15; i >= 0; i--) begin
        c = r | (64'd1 << i);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    function void note_particle(particle_t p);
      longint dx, dy;
      set_mean_t res;
      if (particles < MAX_PARTICLES) begin
        dx = wrapped_delta(p.particle_x, p.robot_x, width_ext);
        dy = wrapped_delta(p.particle_y, p.robot_y, height_ext);
        dist_sum += floor_root(longint'(dx * dx + dy * dy));
        particles++;
      end
      if (p.last_particle) begin
        res.mean_error     = 16'(dist_sum / ((particles == 0) ? 1 : particles));
        res.particle_total = CNT_W'(particles);
        pending_means.push_back(res);
        dist_sum  = 0;
        particles = 0;
      end
    endfunction

    function void check_mean(logic [15:0] mean, logic [CNT_W-1:0] total);
      set_mean_t exp_res;
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected result mean_error %0d particle_total %0d",
                 $time, mean, total);
        errors++;
        return;
      end
      exp_res = pending_means.pop_front();
      if (exp_res.mean_error !== mean) begin
        $display("%0t: mean_error expected %0d actual %0d", $time, exp_res.mean_error, mean);
        errors++;
      end
      if (exp_res.particle_total !== total) begin
        $display("%0t: particle_total expected %0d actual %0d",
                 $time, exp_res.particle_total, total);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i;
  logic [15:0]          cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [15:0]          particle_x_i;
  logic [15:0]          particle_y_i;
  logic [15:0]          robot_x_i;
  logic [15:0]          robot_y_i;
  logic                 last_particle_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [15:0]          mean_error_o;
  logic [CNT_W-1:0]     particle_total_o;

  set_mean_checker board;
  int unsigned     send_idle_pct;
  int unsigned     stall_pct;
  logic            stall_hold;
  int unsigned     quiet_cycles;

  mean_wrapped_position_error DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .particle_x_i     (particle_x_i),
    .particle_y_i     (particle_y_i),
    .robot_x_i        (robot_x_i),
    .robot_y_i        (robot_y_i),
    .last_particle_i  (last_particle_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .mean_error_o     (mean_error_o),
    .particle_total_o (particle_total_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    out_stall_i <= stall_hold || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      board.note_particle('{particle_x_i, particle_y_i, robot_x_i, robot_y_i,
                            last_particle_i});
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_mean(mean_error_o, particle_total_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_particle(input particle_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    particle_x_i    <= p.particle_x;
    particle_y_i    <= p.particle_y;
    robot_x_i       <= p.robot_x;
    robot_y_i       <= p.robot_y;
    last_particle_i <= p.last_particle;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_extents(input logic [15:0] w, input logic [15:0] h);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_WORLD_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_extent(REG_WORLD_WIDTH, w);
    cfg_index_i <= REG_WORLD_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_extent(REG_WORLD_HEIGHT, h);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void pick_axis(input logic [15:0] ext, output logic [15:0] a,
                                    output logic [15:0] b);
    int unsigned e, h;
    int off;
    e = (ext == 0) ? 1 : ext;
    h = e / 2;
    off = int'($urandom_range(2)) - 1;
    case ($urandom_range(3))
      0: begin
        a = 16'($urandom);
        b = 16'($urandom);
      end
      1: begin
        a = 16'($urandom_range(e - 1));
        b = 16'($urandom_range(e - 1));
      end
      2: begin
        b = 16'($urandom);
        a = 16'(int'(b) + int'($urandom_range(64)) - 32);
      end
      default: begin
        b = 16'($urandom);
        a = ($urandom_range(1) != 0) ? 16'(int'(b) + int'(h) + off) :
                                       16'(int'(b) - int'(h) + off);
      end
    endcase
  endfunction

  task automatic send_random_set(input int unsigned n);
    particle_t p;
    for (int unsigned k = 0; k < n; k++) begin
      pick_axis(board.width_ext, p.particle_x, p.robot_x);
      pick_axis(board.height_ext, p.particle_y, p.robot_y);
      p.last_particle = (k == n - 1);
      send_particle(p);
    end
  endtask

  initial begin
    logic [15:0] widths[6];
    logic [15:0] heights[6];
    int unsigned sent, n;
    widths  = '{16'd65535, 16'd1, 16'd0, 16'd301, 16'd25600, 16'd0};
    heights = '{16'd65535, 16'd1, 16'd40000, 16'd257, 16'd25600, 16'd0};
    widths[5]  = 16'($urandom);
    heights[5] = 16'($urandom);
    board = new();
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_WORLD_WIDTH;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    particle_x_i    = '0;
    particle_y_i    = '0;
    robot_x_i       = '0;
    robot_y_i       = '0;
    last_particle_i = 1'b0;
    out_stall_i     = 1'b0;
    stall_hold      = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    quiet_cycles    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_particle('{0, 0, 0, 0, 1});
    send_particle('{65535, 65535, 0, 0, 1});
    send_particle('{0, 0, 65535, 65535, 1});
    send_particle('{12800, 0, 0, 12800, 1});
    send_particle('{0, 25599, 12801, 0, 1});
    send_particle('{12799, 12801, 0, 0, 0});
    send_particle('{40000, 100, 300, 60000, 0});
    send_particle('{25600, 25600, 0, 0, 1});
    send_particle('{1234, 4321, 1234, 4321, 1});
    send_particle('{32767, 45000, 7000, 65535, 1});
    wait_drained();

    // hold the output while single-item sets keep arriving
    fork
      begin
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        stall_hold <= 1'b0;
      end
    join_none
    repeat (10) send_random_set(1);
    wait_drained();

    for (int s = 0; s < 6; s++) begin
      write_extents(widths[s], heights[s]);
      for (int mode = 0; mode < 4; mode++) begin
        send_idle_pct = (mode == 1) ? 78 : (mode == 3) ? 19 : 0;
        stall_pct    <= (mode == 2) ? 78 : (mode == 3) ? 19 : 0;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
          n = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
          send_random_set(n);
          sent += n;
        end
      end
      send_idle_pct = 0;
      stall_pct    <= 0;
      wait_drained();
    end

    // overfill one set past the particle limit
    write_extents(16'($urandom), 16'($urandom));
    send_random_set(MAX_PARTICLES + 6);
    wait_drained();

    if (board.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, board.pending());
    end
    if (board.errors == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
